// ===== src/vnt_pkg.sv =====
`default_nettype none
package vnt_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned RGB_W = 24;
  localparam int unsigned PIX_W = 12;
  localparam int unsigned CH_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RGB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_RGB = 3'd4;

  localparam logic [DIM_W-1:0] RST_IMG_WIDTH = 13'd64;
  localparam logic [DIM_W-1:0] RST_IMG_HEIGHT = 13'd64;
  localparam logic [SCALE_W-1:0] RST_NOISE_SCALE = 16'd1536;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam int unsigned DEF_MAX_DIM = 4096;
  localparam int unsigned DEF_BORDER_PIXELS = 8;

endpackage
`default_nettype wire

// ===== src/value_noise_texture_pixel.sv =====
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, in_pix_x, in_pix_y
// out     | output    | out_valid, out_stall, out_red, out_green, out_blue
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// One pixel is accepted per cycle while in_stall is low; results leave in transfer order.
// The pipeline holds two 36-step restoring dividers, one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline, and in_stall is raised in the same cycle.
`default_nettype none
module value_noise_texture_pixel #(
  parameter int unsigned MAX_DIM = vnt_pkg::DEF_MAX_DIM,
  parameter int unsigned BORDER_PIXELS = vnt_pkg::DEF_BORDER_PIXELS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [vnt_pkg::PIX_W-1:0]       in_pix_x,
  input  wire logic [vnt_pkg::PIX_W-1:0]       in_pix_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [vnt_pkg::CH_W-1:0]             out_red,
  output logic [vnt_pkg::CH_W-1:0]             out_green,
  output logic [vnt_pkg::CH_W-1:0]             out_blue,
  input  wire logic                            cfg_we,
  input  wire logic [vnt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vnt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vnt_pkg::*;

  localparam int unsigned NW = PIX_W + SCALE_W + 8;
  localparam int unsigned NS = NW + 10;
  localparam int unsigned QI = NW;
  localparam int unsigned PW = PIX_W + SCALE_W;

  logic [DIM_W-1:0] img_width_r, img_height_r;
  logic [SCALE_W-1:0] noise_scale_r;
  logic [RGB_W-1:0] base_rgb_r, var_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r <= RST_IMG_WIDTH;
      img_height_r <= RST_IMG_HEIGHT;
      noise_scale_r <= RST_NOISE_SCALE;
      base_rgb_r <= '0;
      var_rgb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH: img_width_r <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_data[DIM_W-1:0];
        REG_NOISE_SCALE: noise_scale_r <= cfg_data[SCALE_W-1:0];
        REG_BASE_RGB: base_rgb_r <= cfg_data[RGB_W-1:0];
        REG_VAR_RGB: var_rgb_r <= cfg_data[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = img_width_r;
    h_eff = img_height_r;
    if (img_width_r == '0) w_eff = DIM_W'(1);
    else if (32'(img_width_r) > MAX_DIM) w_eff = DIM_W'(MAX_DIM);
    if (img_height_r == '0) h_eff = DIM_W'(1);
    else if (32'(img_height_r) > MAX_DIM) h_eff = DIM_W'(MAX_DIM);
  end

  logic en;
  logic [NS-1:0] vld_r, dark_r;
  logic dark_in;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[NS-1];

  always_comb begin
    dark_in = (32'(in_pix_x) < BORDER_PIXELS) || (32'(in_pix_y) < BORDER_PIXELS) ||
              (32'(in_pix_x) + BORDER_PIXELS >= 32'(w_eff)) ||
              (32'(in_pix_y) + BORDER_PIXELS >= 32'(h_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dark_r <= {dark_r[NS-2:0], dark_in};
    end
  end

  logic [NW-1:0] nqx_r [0:NW];
  logic [NW-1:0] nqy_r [0:NW];
  logic [DIM_W-1:0] remx_r [0:NW];
  logic [DIM_W-1:0] remy_r [0:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      nqx_r[0] <= {PW'(in_pix_x) * PW'(noise_scale_r), 8'd0};
      nqy_r[0] <= {PW'(in_pix_y) * PW'(noise_scale_r), 8'd0};
      remx_r[0] <= '0;
      remy_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DIM_W:0] tx, ty;
    logic gex, gey;
    always_comb begin
      tx = {remx_r[k], nqx_r[k][NW-1]};
      ty = {remy_r[k], nqy_r[k][NW-1]};
      gex = tx >= {1'b0, w_eff};
      gey = ty >= {1'b0, h_eff};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k+1] <= gex ? DIM_W'(tx - {1'b0, w_eff}) : DIM_W'(tx);
        remy_r[k+1] <= gey ? DIM_W'(ty - {1'b0, h_eff}) : DIM_W'(ty);
        nqx_r[k+1] <= {nqx_r[k][NW-2:0], gex};
        nqy_r[k+1] <= {nqy_r[k][NW-2:0], gey};
      end
    end
  end

  logic [31:0] ix, iy;
  assign ix = 32'(nqx_r[QI][NW-1:16]);
  assign iy = 32'(nqy_r[QI][NW-1:16]);

  logic [31:0] ax0_r, ax1_r, by0_r, by1_r;
  logic [31:0] g_r [0:3];
  logic [31:0] m_r [0:3];
  logic [15:0] fx_r [0:2];
  logic [15:0] fy_r [0:4];
  logic [31:0] h00, h10, h01, h11;

  assign h00 = ax0_r + by0_r;
  assign h10 = ax1_r + by0_r;
  assign h01 = ax0_r + by1_r;
  assign h11 = ax1_r + by1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r <= ix * HASH_MUL_X;
      ax1_r <= (ix + 32'd1) * HASH_MUL_X;
      by0_r <= iy * HASH_MUL_Y;
      by1_r <= (iy + 32'd1) * HASH_MUL_Y;
      fx_r[0] <= nqx_r[QI][15:0];
      fy_r[0] <= nqy_r[QI][15:0];
      g_r[0] <= h00 ^ (h00 >> 13);
      g_r[1] <= h10 ^ (h10 >> 13);
      g_r[2] <= h01 ^ (h01 >> 13);
      g_r[3] <= h11 ^ (h11 >> 13);
      for (int i = 0; i < 4; i++) m_r[i] <= g_r[i] * HASH_MUL_MIX;
      for (int i = 1; i < 3; i++) fx_r[i] <= fx_r[i-1];
      for (int i = 1; i < 5; i++) fy_r[i] <= fy_r[i-1];
    end
  end

  logic [16:0] fxc, fyc;
  assign fxc = 17'h10000 - {1'b0, fx_r[2]};
  assign fyc = 17'h10000 - {1'b0, fy_r[4]};

  logic [31:0] p_r [0:3];
  logic [31:0] row0_r, row1_r;
  logic [47:0] q0_r, q1_r;
  logic [15:0] n_r;
  logic [48:0] qsum;
  assign qsum = {1'b0, q0_r} + {1'b0, q1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 32'(m_r[0][30:15] * fxc);
      p_r[1] <= 32'(m_r[1][30:15] * fx_r[2]);
      p_r[2] <= 32'(m_r[2][30:15] * fxc);
      p_r[3] <= 32'(m_r[3][30:15] * fx_r[2]);
      row0_r <= p_r[0] + p_r[1];
      row1_r <= p_r[2] + p_r[3];
      q0_r <= 48'(row0_r * fyc);
      q1_r <= 48'(row1_r * fy_r[4]);
      n_r <= qsum[47:32];
    end
  end

  logic signed [17:0] dn;
  assign dn = $signed({1'b0, n_r, 1'b0}) - 18'sd65536;

  logic signed [26:0] v_r [0:2];
  logic [CH_W-1:0] ch_r [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    localparam int unsigned LO = (2 - c) * CH_W;
    logic [CH_W-1:0] cl;
    logic [9:0] c3;
    always_comb begin
      if (v_r[c][26]) cl = '0;
      else if (v_r[c][25:24] != 2'b00) cl = '1;
      else cl = v_r[c][23:16];
      c3 = 10'(cl) * 10'd3;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[c] <= $signed({3'b000, base_rgb_r[LO +: CH_W], 16'd0}) +
                  27'($signed({1'b0, var_rgb_r[LO +: CH_W]}) * dn);
        ch_r[c] <= dark_r[NS-2] ? c3[9:2] : cl;
      end
    end
  end

  assign out_red = ch_r[0];
  assign out_green = ch_r[1];
  assign out_blue = ch_r[2];

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("pipeline moved while stalled");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0) else $error("valid bits survive reset");
  a_dark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dark_r[NS-1] |-> out_red <= 8'd191 && out_green <= 8'd191 &&
    out_blue <= 8'd191) else $error("darkened pixel too bright");
`endif

endmodule
`default_nettype wire
